### design/indexed_deque_assert.svh
// assertion macros shared by the indexed deque rtl
// expects clk and arst_n in the scope of each use
`ifndef INDEXED_DEQUE_ASSERT_SVH
`define INDEXED_DEQUE_ASSERT_SVH

// condition holds at every edge out of reset
`define IDQ_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// same-cycle implication
`define IDQ_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define IDQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/idq_pkg.sv
// shared types and constants of the indexed deque
// no dependencies
`default_nettype none

package idq_pkg;

	typedef enum logic [2:0] {
		CMD_ADD_FRONT    = 3'd0,
		CMD_ADD_BACK     = 3'd1,
		CMD_REMOVE_FRONT = 3'd2,
		CMD_REMOVE_BACK  = 3'd3,
		CMD_READ         = 3'd4,
		CMD_WRITE        = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_BADPOS = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		MOP_NONE  = 2'd0,
		MOP_READ  = 2'd1,
		MOP_WRITE = 2'd2
	} mem_op_t;

	localparam int COUNT_OUT_BITS = 11;
	localparam int ITEM_OUT_BITS  = 32;
	localparam int POS_BITS       = 10;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = 2;
	localparam int QFILL_BITS  = 3;

	// decoded command as it travels from front to back
	typedef struct packed {
		mem_op_t                   op;
		status_t                   status;
		logic [COUNT_OUT_BITS-1:0] count;
	} op_ctrl_t;

endpackage

`default_nettype wire

### design/idq_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module idq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### design/idq_front.sv
// command decode and front/count bookkeeping of the indexed deque
// depends on idq_pkg and indexed_deque_assert.svh
`default_nettype none
`include "indexed_deque_assert.svh"

module idq_front
	import idq_pkg::*;
#(
	parameter int CAPACITY  = 1024,
	parameter int ITEM_BITS = 32
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        push,
	input  wire logic [2:0]                  command,
	input  wire logic [ITEM_OUT_BITS-1:0]    item_in,
	input  wire logic [POS_BITS-1:0]         position,
	output op_ctrl_t                         ctrl,
	output logic [$clog2(CAPACITY)-1:0]      addr,
	output logic [ITEM_BITS-1:0]             data
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > POS_BITS) ? CW : POS_BITS;

	logic [AW-1:0] front_q, nxt_front;
	logic [CW-1:0] count_q, nxt_count;
	status_t       st;
	mem_op_t       op;
	logic          is_full, is_empty, pos_ok;

	// ring slot at a given offset from the front, offset below capacity
	function automatic logic [AW-1:0] slot_at(input logic [AW-1:0] base,
	                                          input logic [AW-1:0] off);
		logic [AW:0] s;
		s = {1'b0, base} + {1'b0, off};
		if (s >= (AW+1)'(CAPACITY)) begin
			s = s - (AW+1)'(CAPACITY);
		end
		return s[AW-1:0];
	endfunction

	assign is_full  = (count_q == CW'(CAPACITY));
	assign is_empty = (count_q == '0);
	assign pos_ok   = (PW'(position) < PW'(count_q));

	always_comb begin
		nxt_front = front_q;
		nxt_count = count_q;
		st        = ST_OK;
		op        = MOP_NONE;
		addr      = '0;
		unique case (cmd_t'(command))
			CMD_ADD_FRONT: begin
				if (is_full) begin
					st = ST_FULL;
				end else begin
					nxt_front = (front_q == '0) ? AW'(CAPACITY - 1) : front_q - AW'(1);
					nxt_count = count_q + CW'(1);
					op        = MOP_WRITE;
					addr      = nxt_front;
				end
			end
			CMD_ADD_BACK: begin
				if (is_full) begin
					st = ST_FULL;
				end else begin
					nxt_count = count_q + CW'(1);
					op        = MOP_WRITE;
					addr      = slot_at(front_q, AW'(count_q));
				end
			end
			CMD_REMOVE_FRONT: begin
				if (is_empty) begin
					st = ST_EMPTY;
				end else begin
					nxt_front = slot_at(front_q, AW'(1));
					nxt_count = count_q - CW'(1);
					op        = MOP_READ;
					addr      = front_q;
				end
			end
			CMD_REMOVE_BACK: begin
				if (is_empty) begin
					st = ST_EMPTY;
				end else begin
					nxt_count = count_q - CW'(1);
					op        = MOP_READ;
					addr      = slot_at(front_q, AW'(count_q - CW'(1)));
				end
			end
			CMD_READ: begin
				if (!pos_ok) begin
					st = ST_BADPOS;
				end else begin
					op   = MOP_READ;
					addr = slot_at(front_q, AW'(position));
				end
			end
			CMD_WRITE: begin
				if (!pos_ok) begin
					st = ST_BADPOS;
				end else begin
					op   = MOP_WRITE;
					addr = slot_at(front_q, AW'(position));
				end
			end
			default: begin
				// unused command codes pass through as a no-op
				op = MOP_NONE;
			end
		endcase
	end

	assign ctrl.op     = op;
	assign ctrl.status = st;
	assign ctrl.count  = COUNT_OUT_BITS'(nxt_count);
	assign data        = ITEM_BITS'(item_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
		end else if (push) begin
			front_q <= nxt_front;
			count_q <= nxt_count;
		end
	end

	`IDQ_ASSERT_ALWAYS(a_count_range, count_q <= CW'(CAPACITY), "held count above capacity")
	`IDQ_ASSERT_ALWAYS(a_front_range, AW'(front_q) < (AW+1)'(CAPACITY), "front slot out of ring")
	`IDQ_ASSERT_NEXT(a_error_keeps_state, push && (st != ST_OK),
		(count_q == $past(count_q)) && (front_q == $past(front_q)), "error changed state")

endmodule

`default_nettype wire

### design/idq_queue.sv
// short fifo of decoded commands between front and back
// depends on idq_pkg and indexed_deque_assert.svh
`default_nettype none
`include "indexed_deque_assert.svh"

module idq_queue
	import idq_pkg::*;
#(
	parameter int ADDR_BITS = 10,
	parameter int ITEM_BITS = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire op_ctrl_t             push_ctrl,
	input  wire logic [ADDR_BITS-1:0] push_addr,
	input  wire logic [ITEM_BITS-1:0] push_data,
	output logic                      full,
	input  wire logic                 pop,
	output logic                      pop_valid,
	output op_ctrl_t                  pop_ctrl,
	output logic [ADDR_BITS-1:0]      pop_addr,
	output logic [ITEM_BITS-1:0]      pop_data
);

	op_ctrl_t              ctrl_q [QUEUE_DEPTH];
	logic [ADDR_BITS-1:0]  addr_q [QUEUE_DEPTH];
	logic [ITEM_BITS-1:0]  data_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QFILL_BITS-1:0] fill_q;

	assign full      = (fill_q == QFILL_BITS'(QUEUE_DEPTH));
	assign pop_valid = (fill_q != '0);
	assign pop_ctrl  = ctrl_q[rd_ptr_q];
	assign pop_addr  = addr_q[rd_ptr_q];
	assign pop_data  = data_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ctrl_q[wr_ptr_q] <= push_ctrl;
			addr_q[wr_ptr_q] <= push_addr;
			data_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_BITS'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + QFILL_BITS'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - QFILL_BITS'(1);
			end
		end
	end

	`IDQ_ASSERT_IMPLY(a_no_pop_empty, pop, fill_q != '0, "pop from empty queue")
	`IDQ_ASSERT_IMPLY(a_no_push_full, push, !full, "push into full queue")

endmodule

`default_nettype wire

### design/idq_back.sv
// ring store access and result register of the indexed deque
// depends on idq_pkg and idq_ram
`default_nettype none

module idq_back
	import idq_pkg::*;
#(
	parameter int CAPACITY  = 1024,
	parameter int ITEM_BITS = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         op_valid,
	input  wire op_ctrl_t                     op_ctrl,
	input  wire logic [$clog2(CAPACITY)-1:0]  op_addr,
	input  wire logic [ITEM_BITS-1:0]         op_data,
	output logic                              op_pop,
	output logic                              res_valid,
	input  wire logic                         res_stall,
	output logic [ITEM_OUT_BITS-1:0]          item_out,
	output logic [COUNT_OUT_BITS-1:0]         item_count,
	output status_t                           status
);

	logic                        valid_s1;
	op_ctrl_t                    ctrl_s1;
	logic                        move_s1;
	logic [ITEM_BITS-1:0]        rd_data;
	logic                        res_valid_q;
	logic [ITEM_OUT_BITS-1:0]    item_q;
	logic [COUNT_OUT_BITS-1:0]   count_q;
	status_t                     status_q;

	assign move_s1 = valid_s1 && (!res_valid_q || !res_stall);
	assign op_pop  = op_valid && (!valid_s1 || move_s1);

	idq_ram #(
		.WIDTH (ITEM_BITS),
		.DEPTH (CAPACITY)
	) u_ring (
		.clk   (clk),
		.we    (op_pop && (op_ctrl.op == MOP_WRITE)),
		.waddr (op_addr),
		.wdata (op_data),
		.re    (op_pop && (op_ctrl.op == MOP_READ)),
		.raddr (op_addr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (op_pop) begin
				valid_s1 <= 1'b1;
			end else if (move_s1) begin
				valid_s1 <= 1'b0;
			end
			if (move_s1) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (op_pop) begin
			ctrl_s1 <= op_ctrl;
		end
		if (move_s1) begin
			item_q   <= (ctrl_s1.op == MOP_READ) ? ITEM_OUT_BITS'(rd_data) : '0;
			count_q  <= ctrl_s1.count;
			status_q <= ctrl_s1.status;
		end
	end

	assign res_valid  = res_valid_q;
	assign item_out   = item_q;
	assign item_count = count_q;
	assign status     = status_q;

endmodule

`default_nettype wire

### design/indexed_deque.sv
// top level of the indexed deque: front, command queue and back
// depends on idq_pkg, idq_front, idq_queue, idq_back and idq_ram
`default_nettype none

// Indexed deque: a double-ended queue of CAPACITY items of ITEM_BITS bits
// held in one ring memory, with a front slot and a held count. Each command
// transfer (add front, add back, remove front, remove back, read at a
// position, write at a position; positions count from the front) produces
// exactly one result transfer carrying the item removed or read, the count
// after the command and a status (ok, full, empty, bad position). Errors and
// the unused command codes leave the deque unchanged and return item zero.
// The front stage updates the front slot and count as it takes a command, so
// a new command is taken on every clock while the command queue has room;
// sustained rate is one command per cycle while results are not stalled.
// The back stage reads or writes the ring memory, whose read is registered;
// a command passes the queue, the ring read stage and the result register.
// A four-entry queue sits between front and back, so cmd_stall only rises
// after the result side has held off long enough to fill it. The ring needs
// no clearing after reset: only slots that were written are ever read.

module indexed_deque
	import idq_pkg::*;
#(
	parameter int CAPACITY  = 1024,
	parameter int ITEM_BITS = 32
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// command channel
	input  wire logic                       cmd_valid,
	output logic                            cmd_stall,
	input  wire logic [2:0]                 command,
	input  wire logic [ITEM_OUT_BITS-1:0]   item_in,
	input  wire logic [POS_BITS-1:0]        position,
	// result channel
	output logic                            res_valid,
	input  wire logic                       res_stall,
	output logic [ITEM_OUT_BITS-1:0]        item_out,
	output logic [COUNT_OUT_BITS-1:0]       item_count,
	output logic [1:0]                      status
);

	localparam int AW = $clog2(CAPACITY);

	// front to queue
	logic                 push;
	logic                 q_full;
	op_ctrl_t             push_ctrl;
	logic [AW-1:0]        push_addr;
	logic [ITEM_BITS-1:0] push_data;

	// queue to back
	logic                 pop;
	logic                 pop_valid;
	op_ctrl_t             pop_ctrl;
	logic [AW-1:0]        pop_addr;
	logic [ITEM_BITS-1:0] pop_data;

	status_t              res_status;

	// a command transfers whenever the queue has room
	assign cmd_stall = q_full;
	assign push      = cmd_valid && !q_full;

	idq_front #(
		.CAPACITY  (CAPACITY),
		.ITEM_BITS (ITEM_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.command  (command),
		.item_in  (item_in),
		.position (position),
		.ctrl     (push_ctrl),
		.addr     (push_addr),
		.data     (push_data)
	);

	idq_queue #(
		.ADDR_BITS (AW),
		.ITEM_BITS (ITEM_BITS)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_ctrl (push_ctrl),
		.push_addr (push_addr),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.pop_valid (pop_valid),
		.pop_ctrl  (pop_ctrl),
		.pop_addr  (pop_addr),
		.pop_data  (pop_data)
	);

	// ring access and result register
	idq_back #(
		.CAPACITY  (CAPACITY),
		.ITEM_BITS (ITEM_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.op_valid   (pop_valid),
		.op_ctrl    (pop_ctrl),
		.op_addr    (pop_addr),
		.op_data    (pop_data),
		.op_pop     (pop),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.item_out   (item_out),
		.item_count (item_count),
		.status     (res_status)
	);

	assign status = res_status;

endmodule

`default_nettype wire

### tb/sv/idq_result_checker.sv
// result checker for the indexed deque: watches both channels, predicts
// each result from its own model of the ring and compares field by field
// depends on idq_pkg
`default_nettype none

module idq_result_checker
	import idq_pkg::*;
#(
	parameter int CAPACITY = 1024
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cmd_valid,
	input  wire logic                      cmd_stall,
	input  wire logic [2:0]                command,
	input  wire logic [ITEM_OUT_BITS-1:0]  item_in,
	input  wire logic [POS_BITS-1:0]       position,
	input  wire logic                      res_valid,
	input  wire logic                      res_stall,
	input  wire logic [ITEM_OUT_BITS-1:0]  item_out,
	input  wire logic [COUNT_OUT_BITS-1:0] item_count,
	input  wire logic [1:0]                status,
	output int                             mismatches,
	output int                             outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [ITEM_OUT_BITS-1:0]  item;
		logic [COUNT_OUT_BITS-1:0] count;
		status_t                   status;
	} deque_result_t;

	logic [ITEM_OUT_BITS-1:0] ring_image [CAPACITY];
	int front_slot;
	int held;
	deque_result_t expected_results [$];
	int errors;

	initial begin
		mismatches = 0;
		outstanding = 0;
		errors = 0;
		front_slot = 0;
		held = 0;
	end

	function automatic int ring_slot(int off);
		int s;
		s = front_slot + off;
		if (s >= CAPACITY)
			s -= CAPACITY;
		return s;
	endfunction

	task automatic apply_deque_command(input logic [2:0] cmd, input logic [ITEM_OUT_BITS-1:0] data,
			input logic [POS_BITS-1:0] pos, output deque_result_t r);
		r.item = '0;
		r.status = ST_OK;
		case (cmd)
			CMD_ADD_FRONT: begin
				if (held >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					front_slot = (front_slot == 0) ? CAPACITY - 1 : front_slot - 1;
					ring_image[front_slot] = data;
					held++;
				end
			end
			CMD_ADD_BACK: begin
				if (held >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					ring_image[ring_slot(held)] = data;
					held++;
				end
			end
			CMD_REMOVE_FRONT: begin
				if (held == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.item = ring_image[front_slot];
					front_slot = ring_slot(1);
					held--;
				end
			end
			CMD_REMOVE_BACK: begin
				if (held == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.item = ring_image[ring_slot(held - 1)];
					held--;
				end
			end
			CMD_READ: begin
				if (int'(pos) >= held)
					r.status = ST_BADPOS;
				else
					r.item = ring_image[ring_slot(int'(pos))];
			end
			CMD_WRITE: begin
				if (int'(pos) >= held)
					r.status = ST_BADPOS;
				else
					ring_image[ring_slot(int'(pos))] = data;
			end
			default: begin
			end
		endcase
		r.count = held[COUNT_OUT_BITS-1:0];
	endtask

	always @(posedge clk or negedge arst_n) begin
		deque_result_t want;
		deque_result_t next;
		if (!arst_n) begin
			front_slot = 0;
			held = 0;
			expected_results.delete();
			outstanding <= 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result transfer with none expected: item %h count %0d status %0d",
						$time, item_out, item_count, status);
					errors++;
				end else begin
					want = expected_results.pop_front();
					if (item_out !== want.item) begin
						$display("%0t: item_out expected %h actual %h", $time, want.item, item_out);
						errors++;
					end
					if (item_count !== want.count) begin
						$display("%0t: item_count expected %0d actual %0d",
							$time, want.count, item_count);
						errors++;
					end
					if (status !== want.status) begin
						$display("%0t: status expected %0d actual %0d", $time, want.status, status);
						errors++;
					end
				end
			end
			if (cmd_valid && !cmd_stall) begin
				apply_deque_command(command, item_in, position, next);
				expected_results.push_back(next);
			end
			outstanding <= expected_results.size();
			mismatches <= errors;
		end
	end

endmodule

`default_nettype wire

### tb/sv/tb_indexed_deque.sv
// top of the indexed deque testbench: clock, reset, command stimulus and
// result-side stalls; the verdict comes from idq_result_checker
// depends on idq_pkg, indexed_deque and idq_result_checker
`default_nettype none

module tb_indexed_deque
	import idq_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAPACITY = 1024;

	// command codes the block decodes as no-ops
	localparam logic [2:0] CMD_SPARE_6 = 3'd6;
	localparam logic [2:0] CMD_SPARE_7 = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                      cmd_valid = 1'b0;
	logic                      cmd_stall;
	logic [2:0]                command = CMD_ADD_FRONT;
	logic [ITEM_OUT_BITS-1:0]  item_in = '0;
	logic [POS_BITS-1:0]       position = '0;
	logic                      res_valid;
	logic                      res_stall = 1'b0;
	logic [ITEM_OUT_BITS-1:0]  item_out;
	logic [COUNT_OUT_BITS-1:0] item_count;
	logic [1:0]                status;

	int mismatches;
	int outstanding;

	// stimulus-side view of the fill level, only used to steer the mix
	int fill_level = 0;
	bit send_gaps_on = 1'b1;
	bit stall_bursts_on = 1'b1;
	int stall_left = 0;

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	indexed_deque #(
		.CAPACITY  (CAPACITY),
		.ITEM_BITS (32)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.command    (command),
		.item_in    (item_in),
		.position   (position),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.item_out   (item_out),
		.item_count (item_count),
		.status     (status)
	);

	idq_result_checker #(
		.CAPACITY (CAPACITY)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_stall   (cmd_stall),
		.command     (command),
		.item_in     (item_in),
		.position    (position),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.item_out    (item_out),
		.item_count  (item_count),
		.status      (status),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// result side holds off in random bursts while enabled
	always @(posedge clk) begin
		if (stall_bursts_on && stall_left > 0) begin
			res_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (stall_bursts_on && $urandom_range(0, 9) == 0) begin
			res_stall <= 1'b1;
			stall_left <= $urandom_range(0, 18);
		end else begin
			res_stall <= 1'b0;
		end
	end

	// one command transfer; an optional idle burst goes ahead of it
	task automatic send_command(input logic [2:0] cmd, input logic [ITEM_OUT_BITS-1:0] data,
			input logic [POS_BITS-1:0] pos);
		if (send_gaps_on && $urandom_range(0, 5) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		command <= cmd;
		item_in <= data;
		position <= pos;
		// hold the payload until the edge that takes it
		do
			@(posedge clk);
		while (cmd_stall);
		case (cmd)
			CMD_ADD_FRONT, CMD_ADD_BACK: if (fill_level < CAPACITY) fill_level++;
			CMD_REMOVE_FRONT, CMD_REMOVE_BACK: if (fill_level > 0) fill_level--;
			default: begin
			end
		endcase
	endtask

	// mostly legal positions, some just past the end, some anywhere in range
	function automatic logic [POS_BITS-1:0] pick_position();
		int r;
		r = $urandom_range(0, 99);
		if (fill_level > 0 && r < 70)
			return POS_BITS'($urandom_range(0, fill_level - 1));
		else if (r < 85)
			return POS_BITS'(fill_level);
		else if (r < 90)
			return (r < 88) ? '1 : '0;
		else
			return POS_BITS'($urandom);
	endfunction

	function automatic logic [ITEM_OUT_BITS-1:0] pick_item();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	// one random command with the given shares of adds and removes (percent)
	task automatic send_random_command(input int add_pct, input int remove_pct);
		int r;
		logic [2:0] cmd;
		r = $urandom_range(0, 99);
		if (r < add_pct)
			cmd = $urandom_range(0, 1) ? CMD_ADD_FRONT : CMD_ADD_BACK;
		else if (r < add_pct + remove_pct)
			cmd = $urandom_range(0, 1) ? CMD_REMOVE_FRONT : CMD_REMOVE_BACK;
		else if (r < 98)
			cmd = $urandom_range(0, 1) ? CMD_READ : CMD_WRITE;
		else
			cmd = $urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7;
		send_command(cmd, pick_item(), pick_position());
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty-deque errors, spare codes, extremes of the fields
		send_command(CMD_REMOVE_FRONT, '0, '0);
		send_command(CMD_REMOVE_BACK, '1, '1);
		send_command(CMD_READ, '0, '0);
		send_command(CMD_WRITE, 32'hDEAD_BEEF, '0);
		send_command(CMD_SPARE_6, '1, '1);
		send_command(CMD_SPARE_7, '0, '0);
		send_command(CMD_ADD_BACK, '1, '0);
		send_command(CMD_ADD_FRONT, '0, '1);
		send_command(CMD_ADD_BACK, 32'hA5A5_5A5A, '0);
		send_command(CMD_READ, '0, 10'd0);
		send_command(CMD_READ, '0, 10'd1);
		send_command(CMD_READ, '0, 10'd2);
		// a position equal to the count is already out of range
		send_command(CMD_READ, '0, 10'd3);
		send_command(CMD_WRITE, 32'h1234_5678, 10'd3);
		send_command(CMD_READ, '0, '1);
		send_command(CMD_WRITE, 32'h1234_5678, 10'd1);
		send_command(CMD_WRITE, 32'h5A5A_A5A5, 10'd2);
		send_command(CMD_READ, '0, 10'd1);
		send_command(CMD_REMOVE_BACK, '0, '0);
		send_command(CMD_REMOVE_FRONT, '0, '0);
		send_command(CMD_REMOVE_FRONT, '0, '0);
		send_command(CMD_REMOVE_BACK, '0, '0);
		// add at the front of the empty deque and take it off the back
		send_command(CMD_ADD_FRONT, 32'h0000_0001, '0);
		send_command(CMD_REMOVE_BACK, '0, '0);

		// fill up to capacity, idling switched on and off in stretches
		while (fill_level < CAPACITY) begin
			if ($urandom_range(0, 99) == 0)
				send_gaps_on = !send_gaps_on;
			if ($urandom_range(0, 99) == 0)
				stall_bursts_on = !stall_bursts_on;
			send_random_command(90, 3);
		end

		// balanced mix around full: full errors, reads near the top end
		send_gaps_on = 1'b1;
		stall_bursts_on = 1'b1;
		repeat (120) send_random_command(35, 30);

		// last stretch with no idling on either side
		send_gaps_on = 1'b0;
		stall_bursts_on = 1'b0;
		repeat (80) send_random_command(35, 30);
		cmd_valid <= 1'b0;

		// drain: outstanding is a registered copy of the checker's queue size
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// watchdog far beyond the slowest legal run
	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire

### filelist.f
+incdir+design
design/idq_pkg.sv
design/idq_ram.sv
design/idq_front.sv
design/idq_queue.sv
design/idq_back.sv
design/indexed_deque.sv
tb/sv/idq_result_checker.sv
tb/sv/tb_indexed_deque.sv
